// ===== rtl/ihl_pkg.sv =====
// Shared types and constants of the hex record loader.
package ihl_pkg;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_LEN_HI = 4'd1,
        PH_LEN_LO = 4'd2,
        PH_ADDR0  = 4'd3,
        PH_ADDR1  = 4'd4,
        PH_ADDR2  = 4'd5,
        PH_ADDR3  = 4'd6,
        PH_TYP_HI = 4'd7,
        PH_TYP_LO = 4'd8,
        PH_DAT_HI = 4'd9,
        PH_DAT_LO = 4'd10
    } phase_t;

    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_PROGRAM = 2'd1;
    localparam logic [1:0] KIND_EEPROM  = 2'd2;

    localparam logic [7:0] REC_DATA     = 8'd0;
    localparam logic [7:0] REC_EOF      = 8'd1;
    localparam logic [7:0] REC_EXT_LIN  = 8'd4;

    localparam logic [7:0] REPLY_NEXT      = 8'h11;
    localparam logic [7:0] REPLY_FINISH    = 8'h55;
    localparam logic [7:0] REPLY_PROTECTED = 8'h80;
    localparam logic [7:0] REPLY_CMD       = 8'd66;

    localparam logic [15:0] EEPROM_SPACE   = 16'h00F0;
    localparam logic [7:0]  CHAR_COLON     = 8'h3A;
    localparam logic [7:0]  CHAR_A         = 8'h41;
    localparam logic [7:0]  CHAR_ZERO      = 8'h30;
    localparam logic [7:0]  ALPHA_OFFSET   = 8'd55;

    localparam logic [7:0]  CMD_CHAR_RESET = 8'd67;
    localparam logic [15:0] PROT_TOP_RESET = 16'd2047;

    localparam logic REG_CMD_CHAR = 1'b0;
    localparam logic REG_PROT_TOP = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [16:0] addr;
        logic [7:0]  data;
        logic        last;
    } result_t;

    // Results produced by one character, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    slot1;
        result_t    slot0;
    } emit_t;

endpackage

// ===== rtl/ihl_parser.sv =====
// Record parser: state registers and per-character result generation.
module ihl_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          rx_char,
    input  logic [7:0]          command_char,
    input  logic [15:0]         protected_top,
    output ihl_pkg::emit_t      emit
);

    ihl_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  length_reg, length_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  index_reg, index_next;
    logic [15:0] upper_reg, upper_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic        finished_reg, finished_next;

    logic [7:0]  digit;
    logic [7:0]  byte_val;
    logic [7:0]  index_inc;
    logic [8:0]  index_plus1;
    logic        complete;
    logic [1:0]  n;
    ihl_pkg::result_t slot [2];

    assign digit = (rx_char >= ihl_pkg::CHAR_A) ? rx_char - ihl_pkg::ALPHA_OFFSET
                                                : rx_char - ihl_pkg::CHAR_ZERO;
    assign byte_val    = {hold_reg[3:0], 4'b0000} + digit;
    assign index_inc   = index_reg + 8'd1;
    assign index_plus1 = {1'b0, index_reg} + 9'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        hold_next     = hold_reg;
        length_next   = length_reg;
        addr_next     = addr_reg;
        type_next     = type_reg;
        index_next    = index_reg;
        upper_next    = upper_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        finished_next = finished_reg;
        complete      = 1'b0;
        n             = 2'd0;
        slot[0]       = '0;
        slot[1]       = '0;

        if (take && !finished_reg)
        begin
            case (phase_reg)
                ihl_pkg::PH_HUNT:
                begin
                    if (rx_char == command_char)
                    begin
                        slot[n[0]] = '{ihl_pkg::KIND_REPLY, 17'd0, ihl_pkg::REPLY_CMD, 1'b0};
                        n = n + 2'd1;
                    end
                    if (rx_char == ihl_pkg::CHAR_COLON)
                        phase_next = ihl_pkg::PH_LEN_HI;
                end
                ihl_pkg::PH_LEN_HI:
                begin
                    hold_next  = digit;
                    phase_next = ihl_pkg::PH_LEN_LO;
                end
                ihl_pkg::PH_TYP_HI:
                begin
                    hold_next  = digit;
                    phase_next = ihl_pkg::PH_TYP_LO;
                end
                ihl_pkg::PH_DAT_HI:
                begin
                    hold_next  = digit;
                    phase_next = ihl_pkg::PH_DAT_LO;
                end
                ihl_pkg::PH_LEN_LO:
                begin
                    length_next = byte_val;
                    addr_next   = '0;
                    phase_next  = ihl_pkg::PH_ADDR0;
                end
                ihl_pkg::PH_ADDR0:
                begin
                    addr_next  = {addr_reg[11:0], 4'b0000} + {8'd0, digit};
                    phase_next = ihl_pkg::PH_ADDR1;
                end
                ihl_pkg::PH_ADDR1:
                begin
                    addr_next  = {addr_reg[11:0], 4'b0000} + {8'd0, digit};
                    phase_next = ihl_pkg::PH_ADDR2;
                end
                ihl_pkg::PH_ADDR2:
                begin
                    addr_next  = {addr_reg[11:0], 4'b0000} + {8'd0, digit};
                    phase_next = ihl_pkg::PH_ADDR3;
                end
                ihl_pkg::PH_ADDR3:
                begin
                    addr_next  = {addr_reg[11:0], 4'b0000} + {8'd0, digit};
                    phase_next = ihl_pkg::PH_TYP_HI;
                end
                ihl_pkg::PH_TYP_LO:
                begin
                    type_next   = byte_val;
                    index_next  = '0;
                    first_next  = '0;
                    second_next = '0;
                    if (length_reg == 8'd0)
                        complete = 1'b1;
                    else
                        phase_next = ihl_pkg::PH_DAT_HI;
                end
                ihl_pkg::PH_DAT_LO:
                begin
                    if (index_reg == 8'd0)
                        first_next = byte_val;
                    if (index_reg == 8'd1)
                        second_next = byte_val;
                    if (type_reg == ihl_pkg::REC_DATA)
                    begin
                        if (upper_reg == 16'd0)
                        begin
                            if (addr_reg > protected_top)
                            begin
                                slot[n[0]] = '{ihl_pkg::KIND_PROGRAM,
                                               {1'b0, addr_reg} + {9'd0, index_reg},
                                               byte_val, 1'b0};
                                n = n + 2'd1;
                            end
                        end
                        else if (upper_reg == ihl_pkg::EEPROM_SPACE)
                        begin
                            // even bytes only, and only if an odd partner follows
                            if (!index_reg[0] && (index_plus1 < {1'b0, length_reg}))
                            begin
                                slot[n[0]] = '{ihl_pkg::KIND_EEPROM,
                                               {9'd0, addr_reg[7:0] + {1'b0, index_reg[7:1]}},
                                               byte_val, 1'b0};
                                n = n + 2'd1;
                            end
                        end
                    end
                    index_next = index_inc;
                    if (index_inc == length_reg)
                        complete = 1'b1;
                    else
                        phase_next = ihl_pkg::PH_DAT_HI;
                end
                default:
                begin
                    phase_next = ihl_pkg::PH_HUNT;
                end
            endcase

            if (complete)
            begin
                phase_next = ihl_pkg::PH_HUNT;
                if (type_next == ihl_pkg::REC_EOF)
                begin
                    slot[n[0]] = '{ihl_pkg::KIND_REPLY, 17'd0, ihl_pkg::REPLY_FINISH, 1'b0};
                    n = n + 2'd1;
                    finished_next = 1'b1;
                end
                else if (type_next == ihl_pkg::REC_EXT_LIN)
                begin
                    upper_next = {first_next, second_next};
                    slot[n[0]] = '{ihl_pkg::KIND_REPLY, 17'd0, ihl_pkg::REPLY_NEXT, 1'b0};
                    n = n + 2'd1;
                end
                else if (type_next == ihl_pkg::REC_DATA)
                begin
                    // protected records never emit a write, so two slots suffice
                    if (upper_reg == 16'd0 && addr_reg <= protected_top)
                    begin
                        slot[n[0]] = '{ihl_pkg::KIND_REPLY, 17'd0,
                                       ihl_pkg::REPLY_PROTECTED, 1'b0};
                        n = n + 2'd1;
                    end
                    slot[n[0]] = '{ihl_pkg::KIND_REPLY, 17'd0, ihl_pkg::REPLY_NEXT, 1'b0};
                    n = n + 2'd1;
                end
            end
        end

        if (n == 2'd1)
            slot[0].last = 1'b1;
        else if (n == 2'd2)
            slot[1].last = 1'b1;

        emit.count = n;
        emit.slot0 = slot[0];
        emit.slot1 = slot[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ihl_pkg::PH_HUNT;
            hold_reg     <= '0;
            length_reg   <= '0;
            addr_reg     <= '0;
            type_reg     <= '0;
            index_reg    <= '0;
            upper_reg    <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hold_reg     <= hold_next;
            length_reg   <= length_next;
            addr_reg     <= addr_next;
            type_reg     <= type_next;
            index_reg    <= index_next;
            upper_reg    <= upper_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            finished_reg <= finished_next;
        end
    end

endmodule

// ===== rtl/intel_hex_record_loader_core.sv =====
// Hex record loader top level: input channel, config registers, result queue.
//
// Input channel (in_valid / in_stall, rx_char) takes one ASCII character per
// request. The output channel (out_valid / out_stall) carries reply bytes and
// program / EEPROM byte writes; last marks the final result of a character.
// Registers command_char (0x0) and protected_top (0x4) sit on the APB port.
//
// A character is parsed in the cycle it is accepted; its zero, one or two
// results enter a 4-entry result queue, are registered there and appear on
// the output in order, one result per cycle while out_stall is low. Input
// throughput is one character per cycle while in_stall is low. in_stall rises
// when fewer than two queue entries are free, so a stalled receiver holds
// back the input once the queue fills.
// After an end-of-file record the block consumes characters without
// results until reset. Reset empties the queue, returns the parser to
// hunting for ':' and restores the register reset values.
module intel_hex_record_loader_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_char,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [16:0] target_address,
    output logic [7:0]  payload_byte,
    output logic        last,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  cmd_char_reg;
    logic [15:0] prot_top_reg;
    logic        cfg_write;

    logic                  take;
    logic                  pop;
    ihl_pkg::emit_t        emit;
    ihl_pkg::result_t      fifo_mem [ihl_pkg::FIFO_DEPTH];
    logic [ihl_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ihl_pkg::FIFO_AW:0]   count_reg, count_next;
    logic [ihl_pkg::FIFO_AW-1:0] wr_ptr_b;
    ihl_pkg::result_t      head;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == ihl_pkg::REG_PROT_TOP) ? {16'd0, prot_top_reg}
                                                           : {24'd0, cmd_char_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_char_reg <= ihl_pkg::CMD_CHAR_RESET;
            prot_top_reg <= ihl_pkg::PROT_TOP_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ihl_pkg::REG_CMD_CHAR)
                cmd_char_reg <= pwdata[7:0];
            else
                prot_top_reg <= pwdata[15:0];
        end
    end

    // Input side: room for the worst case of two results
    assign in_stall = (count_reg > (ihl_pkg::FIFO_AW + 1)'(ihl_pkg::FIFO_DEPTH - 2));
    assign take     = in_valid && !in_stall;

    ihl_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .rx_char       (rx_char),
        .command_char  (cmd_char_reg),
        .protected_top (prot_top_reg),
        .emit          (emit)
    );

    // Result queue
    assign head      = fifo_mem[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign wr_ptr_b  = wr_ptr_reg + (ihl_pkg::FIFO_AW)'(1);
    assign count_next = count_reg + (ihl_pkg::FIFO_AW + 1)'(emit.count)
                                  - (ihl_pkg::FIFO_AW + 1)'(pop);

    always_ff @(posedge clk)
    begin
        if (emit.count != 2'd0)
            fifo_mem[wr_ptr_reg] <= emit.slot0;
        if (emit.count == 2'd2)
            fifo_mem[wr_ptr_b] <= emit.slot1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + (ihl_pkg::FIFO_AW)'(emit.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + (ihl_pkg::FIFO_AW)'(1);
            count_reg <= count_next;
        end
    end

    assign result_kind    = head.kind;
    assign target_address = head.addr;
    assign payload_byte   = head.data;
    assign last           = head.last;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (ihl_pkg::FIFO_AW + 1)'(ihl_pkg::FIFO_DEPTH))
        else $error("result queue count above depth");

    a_no_emit_unless_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.count != 2'd0) |-> take)
        else $error("results produced without an accepted request");

    a_last_marks_final: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.count == 2'd2) |-> (!emit.slot0.last && emit.slot1.last))
        else $error("last flag on wrong result of a request");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.count != 2'd0 && !pop) |=> (count_reg > $past(count_reg)))
        else $error("queue count did not grow on push");

endmodule
